FILE: rtl/sqmd_pkg.sv
package sqmd_pkg;

  // geometry of the marker grid
  localparam int GRID_SIDE   = 7;
  localparam int GRID_W      = GRID_SIDE * GRID_SIDE;
  localparam int INNER_SIDE  = 5;
  localparam int INNER_CELLS = INNER_SIDE * INNER_SIDE;
  localparam int NUM_ORIENT  = 4;
  localparam int NUM_CW      = 5;

  // field widths
  localparam int CW_W        = 5;
  localparam int ROW_DIST_W  = 3;
  localparam int DIST_W      = 5;
  localparam int ROT_W       = 2;
  localparam int ID_W        = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = CW_W;

  typedef logic [GRID_W-1:0]      grid_t;
  typedef logic [INNER_CELLS-1:0] inner_t;
  typedef logic [CW_W-1:0]        cw_t;
  typedef cw_t [NUM_CW-1:0]       cw_set_t;
  typedef logic [ROW_DIST_W-1:0]  row_dist_t;
  typedef row_dist_t [INNER_SIDE-1:0] orient_dist_t;
  typedef orient_dist_t [NUM_ORIENT-1:0] all_dist_t;
  typedef logic [DIST_W-1:0]      dist_t;
  typedef dist_t [NUM_ORIENT-1:0] all_sum_t;
  typedef logic [ROT_W-1:0]       rot_t;
  typedef logic [ID_W-1:0]        marker_id_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  // configuration register indexes
  localparam cfg_index_t CFG_CODEWORD_A = cfg_index_t'(0);
  localparam cfg_index_t CFG_CODEWORD_B = cfg_index_t'(1);
  localparam cfg_index_t CFG_CODEWORD_C = cfg_index_t'(2);
  localparam cfg_index_t CFG_CODEWORD_D = cfg_index_t'(3);
  localparam cfg_index_t CFG_CODEWORD_E = cfg_index_t'(4);

  // codeword reset values, bit 4 is column 0
  localparam cw_t CW_A_RESET = cw_t'(31);
  localparam cw_t CW_B_RESET = cw_t'(27);
  localparam cw_t CW_C_RESET = cw_t'(21);
  localparam cw_t CW_D_RESET = cw_t'(31);
  localparam cw_t CW_E_RESET = cw_t'(27);

  // row distances of all orientations, after the first stage
  typedef struct packed {
    logic      valid;
    logic      border_ok;
    inner_t    inner;
    all_dist_t dists;
  } row_stage_t;

  // summed distance per orientation, after the second stage
  typedef struct packed {
    logic     valid;
    logic     border_ok;
    inner_t   inner;
    all_sum_t total;
  } sum_stage_t;

  // any white cell on the outer ring
  function automatic logic border_white(input grid_t g);
    logic w;
    w = 1'b0;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        if (r == 0 || r == GRID_SIDE - 1 || c == 0 || c == GRID_SIDE - 1) begin
          w = w | g[GRID_SIDE * r + c];
        end
      end
    end
    return w;
  endfunction

  // inner 5x5 cells, bit 5*row+col
  function automatic inner_t inner_of(input grid_t g);
    inner_t m;
    for (int r = 0; r < INNER_SIDE; r++) begin
      for (int c = 0; c < INNER_SIDE; c++) begin
        m[INNER_SIDE * r + c] = g[GRID_SIDE * (r + 1) + c + 1];
      end
    end
    return m;
  endfunction

  // new(r,c) = old(4-c, r)
  function automatic inner_t quarter_turn(input inner_t m);
    inner_t d;
    for (int r = 0; r < INNER_SIDE; r++) begin
      for (int c = 0; c < INNER_SIDE; c++) begin
        d[INNER_SIDE * r + c] = m[INNER_SIDE * (INNER_SIDE - 1 - c) + r];
      end
    end
    return d;
  endfunction

  // grid turned k quarter turns
  function automatic inner_t orient_of(input inner_t m, input rot_t k);
    inner_t t;
    t = m;
    for (int i = 0; i < NUM_ORIENT - 1; i++) begin
      if (i < int'(k)) begin
        t = quarter_turn(t);
      end
    end
    return t;
  endfunction

  // row r packed with column 0 at the top bit
  function automatic cw_t row_of(input inner_t m, input int r);
    cw_t v;
    for (int c = 0; c < INNER_SIDE; c++) begin
      v[INNER_SIDE - 1 - c] = m[INNER_SIDE * r + c];
    end
    return v;
  endfunction

  function automatic row_dist_t pop5(input cw_t v);
    row_dist_t n;
    n = '0;
    for (int i = 0; i < CW_W; i++) begin
      n = n + row_dist_t'(v[i]);
    end
    return n;
  endfunction

  // smallest hamming distance of one row to the codewords
  function automatic row_dist_t row_min_dist(input cw_t row, input cw_set_t cw);
    row_dist_t best;
    row_dist_t d;
    best = row_dist_t'(CW_W);
    for (int p = 0; p < NUM_CW; p++) begin
      d = pop5(row ^ cw[p]);
      if (d < best) begin
        best = d;
      end
    end
    return best;
  endfunction

  // columns 1 and 3 of each row, top row most significant
  function automatic marker_id_t id_of(input inner_t m);
    marker_id_t id;
    for (int r = 0; r < INNER_SIDE; r++) begin
      id[ID_W - 1 - 2 * r] = m[INNER_SIDE * r + 1];
      id[ID_W - 2 - 2 * r] = m[INNER_SIDE * r + 3];
    end
    return id;
  endfunction

endpackage

FILE: rtl/sqmd_row_dist.sv
module sqmd_row_dist (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  sqmd_pkg::grid_t      cell_grid,
  input  sqmd_pkg::cw_set_t    cw,
  output sqmd_pkg::row_stage_t stage
);
  import sqmd_pkg::*;

  logic      valid;
  logic      border_ok;
  inner_t    inner;
  all_dist_t dists;
  inner_t    inner_in;
  inner_t    orient [NUM_ORIENT];
  all_dist_t dists_next;

  // four orientations and per-row distances
  always_comb begin
    inner_in = inner_of(cell_grid);
    for (int k = 0; k < NUM_ORIENT; k++) begin
      orient[k] = orient_of(inner_in, rot_t'(k));
      for (int r = 0; r < INNER_SIDE; r++) begin
        dists_next[k][r] = row_min_dist(row_of(orient[k], r), cw);
      end
    end
  end

  // item valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    border_ok <= ~border_white(cell_grid);
    inner     <= inner_in;
    dists     <= dists_next;
  end

  assign stage.valid     = valid;
  assign stage.border_ok = border_ok;
  assign stage.inner     = inner;
  assign stage.dists     = dists;

endmodule

FILE: rtl/sqmd_sum.sv
module sqmd_sum (
  input  logic                 clk,
  input  logic                 rst,
  input  sqmd_pkg::row_stage_t in_stage,
  output sqmd_pkg::sum_stage_t stage
);
  import sqmd_pkg::*;

  logic     valid;
  logic     border_ok;
  inner_t   inner;
  all_sum_t total;
  all_sum_t total_next;

  // sum the five row distances of each orientation
  always_comb begin
    for (int k = 0; k < NUM_ORIENT; k++) begin
      total_next[k] = '0;
      for (int r = 0; r < INNER_SIDE; r++) begin
        total_next[k] = total_next[k] + dist_t'(in_stage.dists[k][r]);
      end
    end
  end

  // item valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_stage.valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    border_ok <= in_stage.border_ok;
    inner     <= in_stage.inner;
    total     <= total_next;
  end

  assign stage.valid     = valid;
  assign stage.border_ok = border_ok;
  assign stage.inner     = inner;
  assign stage.total     = total;

endmodule

FILE: rtl/sqmd_select.sv
module sqmd_select (
  input  logic                   clk,
  input  logic                   rst,
  input  sqmd_pkg::sum_stage_t   in_stage,
  output logic                   done,
  output logic                   border_ok,
  output logic                   found,
  output sqmd_pkg::marker_id_t   marker_id,
  output sqmd_pkg::rot_t         rotation,
  output sqmd_pkg::dist_t        best_distance
);
  import sqmd_pkg::*;

  dist_t      best_d;
  rot_t       best_k;
  logic       found_next;
  marker_id_t id_next;

  // first orientation with the smallest total wins
  always_comb begin
    best_d = in_stage.total[0];
    best_k = '0;
    for (int k = 1; k < NUM_ORIENT; k++) begin
      if (in_stage.total[k] < best_d) begin
        best_d = in_stage.total[k];
        best_k = rot_t'(k);
      end
    end
    found_next = in_stage.border_ok && (best_d == '0);
    id_next    = found_next ? id_of(orient_of(in_stage.inner, best_k)) : '0;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_stage.valid;
    end
  end

  // result fields, all zero when the border is rejected
  always_ff @(posedge clk) begin
    border_ok     <= in_stage.border_ok;
    found         <= found_next;
    marker_id     <= id_next;
    rotation      <= in_stage.border_ok ? best_k : '0;
    best_distance <= in_stage.border_ok ? best_d : '0;
  end

endmodule

FILE: rtl/square_marker_id_decoder_unit.sv
// Square marker id decoder: checks the black border of a 7x7 cell grid and
// matches the inner 5x5 cells, in four orientations, against five codeword
// rows held in configuration registers.
// Input: drive cell_grid and raise start for one cycle per item; an item is
// taken at every edge where start is high and busy is low. busy stays low,
// so a new item may be given in every cycle.
// Output: after an item passes the row-distance, sum and select registers,
// done is high for exactly one cycle with border_ok, found, marker_id,
// rotation and best_distance. The receiver takes the result in that cycle;
// it cannot hold it off. The pipeline has three register stages: row
// distances, per-orientation sums, then orientation select and id
// extraction. Throughput is one item per cycle.
// Configuration: cfg_write with cfg_index 0 to 4 writes codeword_a to
// codeword_e from cfg_data; other indexes are ignored. Write only while no
// item is in flight.
// Reset (rst, synchronous) clears the pipeline valid bits and returns the
// codewords to 31, 27, 21, 31, 27.
module square_marker_id_decoder_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  sqmd_pkg::grid_t        cell_grid,
  input  logic                   cfg_write,
  input  sqmd_pkg::cfg_index_t   cfg_index,
  input  sqmd_pkg::cfg_data_t    cfg_data,
  output logic                   done,
  output logic                   border_ok,
  output logic                   found,
  output sqmd_pkg::marker_id_t   marker_id,
  output sqmd_pkg::rot_t         rotation,
  output sqmd_pkg::dist_t        best_distance
);
  import sqmd_pkg::*;

  cw_set_t    cw;
  row_stage_t row_stage;
  sum_stage_t sum_stage;

  // fully pipelined, never busy
  assign busy = 1'b0;

  // codeword registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cw[0] <= CW_A_RESET;
      cw[1] <= CW_B_RESET;
      cw[2] <= CW_C_RESET;
      cw[3] <= CW_D_RESET;
      cw[4] <= CW_E_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CODEWORD_A: cw[0] <= cw_t'(cfg_data);
        CFG_CODEWORD_B: cw[1] <= cw_t'(cfg_data);
        CFG_CODEWORD_C: cw[2] <= cw_t'(cfg_data);
        CFG_CODEWORD_D: cw[3] <= cw_t'(cfg_data);
        CFG_CODEWORD_E: cw[4] <= cw_t'(cfg_data);
        default: ;
      endcase
    end
  end

  sqmd_row_dist u_row_dist (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .cell_grid(cell_grid),
    .cw       (cw),
    .stage    (row_stage)
  );

  sqmd_sum u_sum (
    .clk     (clk),
    .rst     (rst),
    .in_stage(row_stage),
    .stage   (sum_stage)
  );

  sqmd_select u_select (
    .clk          (clk),
    .rst          (rst),
    .in_stage     (sum_stage),
    .done         (done),
    .border_ok    (border_ok),
    .found        (found),
    .marker_id    (marker_id),
    .rotation     (rotation),
    .best_distance(best_distance)
  );

endmodule
